// ----- sv/mag_validity_gate_beta_ramp_macros.svh -----
// assertion helpers shared by the gate and its divider
`ifndef MAG_VALIDITY_GATE_BETA_RAMP_MACROS_SVH
`define MAG_VALIDITY_GATE_BETA_RAMP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define MVG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define MVG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/mvg_pkg.sv -----
package mvg_pkg;

  // register indexes on the configuration port
  localparam int unsigned CfgIdxW = 4;
  typedef enum logic [CfgIdxW-1:0] {
    REG_NORM_LOW_SQ    = 4'd0,
    REG_NORM_HIGH_SQ   = 4'd1,
    REG_DEBOUNCE_COUNT = 4'd2,
    REG_MAG_TIMEOUT_US = 4'd3,
    REG_TRANSITION_US  = 4'd4,
    REG_BETA_FULL      = 4'd5,
    REG_BETA_FALLBACK  = 4'd6,
    REG_DT_MAX_US      = 4'd7
  } cfg_reg_t;

  // field widths
  localparam int unsigned StampW   = 32;
  localparam int unsigned DtW      = 20;
  localparam int unsigned GainW    = 16;
  localparam int unsigned StreakW  = 16;
  localparam int unsigned TransW   = 24;
  localparam int unsigned ElapsedW = 25;
  localparam int unsigned NormW    = 32;
  localparam int unsigned AxisW    = 16;

  // ramp division: gain * elapsed over transition
  localparam int unsigned DivNumW  = GainW + TransW + 1;
  localparam int unsigned DivRemW  = TransW + 1;

  // shared multiplier operand widths (signed)
  localparam int unsigned MulAW    = GainW + 1;
  localparam int unsigned MulBW    = ElapsedW + 1;
  localparam int unsigned MulPW    = MulAW + MulBW;

  localparam logic [DtW-1:0]     DtFallbackUs = 20'd2000;
  localparam logic [StreakW-1:0] StreakMax    = 16'hFFFF;

  // reset values of the registers
  localparam logic [NormW-1:0]   RstNormLowSq   = 32'd6871948;
  localparam logic [NormW-1:0]   RstNormHighSq  = 32'd25796624;
  localparam logic [StreakW-1:0] RstDebounce    = 16'd20;
  localparam logic [StampW-1:0]  RstMagTimeout  = 32'd500000;
  localparam logic [TransW-1:0]  RstTransition  = 24'd1500000;
  localparam logic [GainW-1:0]   RstBetaFull    = 16'd2687;
  localparam logic [GainW-1:0]   RstBetaFall    = 16'd9830;
  localparam logic [DtW-1:0]     RstDtMax       = 20'd50000;

  // divider status back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- sv/mvg_ramp_div.sv -----
`include "mag_validity_gate_beta_ramp_macros.svh"

// restoring divider, one quotient bit per cycle
module mvg_ramp_div
  import mvg_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DivNumW-1:0] dividend,
  input  logic [TransW-1:0]  divisor,
  output logic [GainW-1:0]   quotient,
  output div_stat_t          stat
);

  localparam int unsigned CntW = $clog2(GainW);

  logic [DivRemW-1:0] rem_r, rem_nxt;
  logic [GainW-1:0]   low_r, low_nxt;
  logic [GainW-1:0]   quo_r, quo_nxt;
  logic [CntW-1:0]    cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [DivRemW-1:0] trial;
  logic               fits;

  // one trial subtract per cycle
  assign trial = {rem_r[DivRemW-2:0], low_r[GainW-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_comb begin
    rem_nxt  = rem_r;
    low_nxt  = low_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      // upper bits already below the divisor since elapsed < transition
      rem_nxt  = dividend[DivNumW-1:GainW];
      low_nxt  = dividend[GainW-1:0];
      quo_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? (trial - {1'b0, divisor}) : trial;
      low_nxt = {low_r[GainW-2:0], 1'b0};
      quo_nxt = {quo_r[GainW-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CntW'(GainW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    low_r <= low_nxt;
    quo_r <= quo_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

  // partial remainder always stays below the divisor
  `MVG_ASSERT_NOW(a_rem_below, busy_r, (rem_r < {1'b0, divisor}), "divider remainder overflow")
  // done only follows a busy cycle
  `MVG_ASSERT_NOW(a_done_after_busy, done_r, $past(busy_r), "divider done without work")
  // a start always sets the divider busy
  `MVG_ASSERT_NEXT(a_start_busy, start, busy_r, "divider did not start")

endmodule

// ----- sv/mag_validity_gate_beta_ramp.sv -----
// magnetometer validity gate with 9-DOF gain ramp
//
// in_*  : one inertial sample per word, valid/ready; in_ready is high only
//         while the sequencer is idle
// out_* : one result word per sample, valid/ready, held in an output register
// cfg_* : register writes, always ready; write only while no sample is in flight
//
// latency from input accept to output valid:
//   5 cycles with no reading and no ramp division,
//   8 cycles with a reading (three squares on the shared multiplier),
//   +18 cycles while the gain ramps (product, 16-step restoring divider, done)
//   so at most 26 cycles, one sample at a time; the next sample is taken the
//   cycle after the result is loaded, even if that result is still waiting
// a stalled receiver holds the finished result in the last sequencer state
// until the output register frees up
// reset (rst_n low, synchronous) restores the register defaults, clears both
// stamps, the streak and the ramp, and marks the field untrusted
`include "mag_validity_gate_beta_ramp_macros.svh"

module mag_validity_gate_beta_ramp
  import mvg_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // sample channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [StampW-1:0]   in_imu_time_us,
  input  logic [StampW-1:0]   in_now_us,
  input  logic                in_mag_present,
  input  logic [StampW-1:0]   in_mag_time_us,
  input  logic signed [AxisW-1:0] in_mag_x,
  input  logic signed [AxisW-1:0] in_mag_y,
  input  logic signed [AxisW-1:0] in_mag_z,
  // result channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic [DtW-1:0]      out_dt_us,
  output logic                out_use_mag,
  output logic [GainW-1:0]    out_beta_out,
  output logic [StreakW-1:0]  out_good_streak,
  // configuration channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [31:0]         cfg_data
);

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_DT   = 11'b00000000010,
    S_SQX  = 11'b00000000100,
    S_SQY  = 11'b00000001000,
    S_SQZ  = 11'b00000010000,
    S_EVAL = 11'b00000100000,
    S_RAMP = 11'b00001000000,
    S_GAIN = 11'b00010000000,
    S_MUL  = 11'b00100000000,
    S_DIV  = 11'b01000000000,
    S_FIN  = 11'b10000000000
  } state_t;

  // configuration registers
  logic [NormW-1:0]   norm_low_r, norm_high_r;
  logic [StreakW-1:0] debounce_r;
  logic [StampW-1:0]  timeout_r;
  logic [TransW-1:0]  transition_r;
  logic [GainW-1:0]   beta_full_r, beta_fall_r;
  logic [DtW-1:0]     dt_max_r;

  // block state
  logic [StampW-1:0]   last_imu_r, last_mag_r;
  logic [StreakW-1:0]  streak_r, streak_nxt;
  logic                bad_r, bad_nxt;
  logic                prev_bad_r;
  logic [ElapsedW-1:0] elapsed_r, elapsed_nxt;

  // per-sample working registers
  state_t                   state_r, state_nxt;
  logic [StampW-1:0]        diff_r, gap_r;
  logic                     present_r;
  logic signed [AxisW-1:0]  x_r, y_r, z_r;
  logic [DtW-1:0]           dt_r;
  logic [NormW-1:0]         acc_r;
  logic [GainW-1:0]         beta_r;

  // output register
  logic                out_valid_r;
  logic [DtW-1:0]      out_dt_r;
  logic                out_use_r;
  logic [GainW-1:0]    out_beta_r;
  logic [StreakW-1:0]  out_streak_r;

  logic                in_acc, load_out;
  logic                div_start;
  div_stat_t           div_stat;
  logic [GainW-1:0]    div_quo;

  // shared multiplier
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [MulPW-1:0] mul_p;
  logic signed [AxisW-1:0] sq_sel;

  // evaluation helpers
  logic                in_win;
  logic [StreakW-1:0]  streak_hit;
  logic [ElapsedW-1:0] elapsed_base;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign load_out  = (state_r == S_FIN) && (!out_valid_r || out_ready);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      norm_low_r   <= RstNormLowSq;
      norm_high_r  <= RstNormHighSq;
      debounce_r   <= RstDebounce;
      timeout_r    <= RstMagTimeout;
      transition_r <= RstTransition;
      beta_full_r  <= RstBetaFull;
      beta_fall_r  <= RstBetaFall;
      dt_max_r     <= RstDtMax;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_NORM_LOW_SQ:    norm_low_r   <= cfg_data;
        REG_NORM_HIGH_SQ:   norm_high_r  <= cfg_data;
        REG_DEBOUNCE_COUNT: debounce_r   <= cfg_data[StreakW-1:0];
        REG_MAG_TIMEOUT_US: timeout_r    <= cfg_data;
        REG_TRANSITION_US:  transition_r <= cfg_data[TransW-1:0];
        REG_BETA_FULL:      beta_full_r  <= cfg_data[GainW-1:0];
        REG_BETA_FALLBACK:  beta_fall_r  <= cfg_data[GainW-1:0];
        REG_DT_MAX_US:      dt_max_r     <= cfg_data[DtW-1:0];
        default: ;
      endcase
    end
  end

  // multiplier operand select: squares of the axes, or gain times elapsed
  always_comb begin
    case (state_r)
      S_SQY:   sq_sel = y_r;
      S_SQZ:   sq_sel = z_r;
      default: sq_sel = x_r;
    endcase
    if (state_r == S_MUL) begin
      mul_a = $signed({1'b0, beta_full_r});
      mul_b = $signed({1'b0, elapsed_r});
    end else begin
      mul_a = MulAW'(sq_sel);
      mul_b = MulBW'(sq_sel);
    end
  end
  assign mul_p = mul_a * mul_b;

  // window test and saturating streak
  assign in_win     = (acc_r >= norm_low_r) && (acc_r <= norm_high_r);
  assign streak_hit = (streak_r == StreakMax) ? streak_r : streak_r + 1'b1;
  assign elapsed_base = prev_bad_r ? '0 : elapsed_r;

  assign div_start = (state_r == S_MUL);

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    streak_nxt  = streak_r;
    bad_nxt     = bad_r;
    elapsed_nxt = elapsed_r;
    case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_DT;
      S_DT:   state_nxt = present_r ? S_SQX : S_EVAL;
      S_SQX:  state_nxt = S_SQY;
      S_SQY:  state_nxt = S_SQZ;
      S_SQZ:  state_nxt = S_EVAL;
      S_EVAL: begin
        if (present_r) begin
          streak_nxt = in_win ? streak_hit : '0;
          bad_nxt    = (in_win ? streak_hit : '0) < debounce_r;
        end else if (gap_r > timeout_r) begin
          streak_nxt = '0;
          bad_nxt    = 1'b1;
        end
        state_nxt = S_RAMP;
      end
      S_RAMP: begin
        // restart on a fresh trust, then advance while short of the end
        if (!bad_r) begin
          if (elapsed_base < {1'b0, transition_r}) begin
            elapsed_nxt = elapsed_base + ElapsedW'(dt_r);
          end else begin
            elapsed_nxt = elapsed_base;
          end
        end
        state_nxt = S_GAIN;
      end
      S_GAIN: begin
        if (bad_r || transition_r == '0 || elapsed_r >= {1'b0, transition_r}) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_MUL:  state_nxt = S_DIV;
      S_DIV:  if (div_stat.done) state_nxt = S_FIN;
      S_FIN:  if (load_out) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and stamps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      last_imu_r <= '0;
      last_mag_r <= '0;
      streak_r   <= '0;
      bad_r      <= 1'b1;
      prev_bad_r <= 1'b1;
      elapsed_r  <= '0;
    end else begin
      state_r   <= state_nxt;
      streak_r  <= streak_nxt;
      bad_r     <= bad_nxt;
      elapsed_r <= elapsed_nxt;
      if (state_r == S_EVAL) prev_bad_r <= bad_r;
      if (in_acc) begin
        last_imu_r <= in_imu_time_us;
        if (in_mag_present) last_mag_r <= in_mag_time_us;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      diff_r    <= in_imu_time_us - last_imu_r;
      gap_r     <= in_now_us - last_mag_r;
      present_r <= in_mag_present;
      x_r       <= in_mag_x;
      y_r       <= in_mag_y;
      z_r       <= in_mag_z;
    end
    // interval clean-up
    if (state_r == S_DT) begin
      if (diff_r == '0 || diff_r > StampW'(dt_max_r)) begin
        dt_r <= DtFallbackUs;
      end else begin
        dt_r <= diff_r[DtW-1:0];
      end
    end
    // squared norm accumulation
    case (state_r)
      S_SQX:   acc_r <= mul_p[NormW-1:0];
      S_SQY,
      S_SQZ:   acc_r <= acc_r + mul_p[NormW-1:0];
      default: ;
    endcase
    // gain pick
    if (state_r == S_GAIN) beta_r <= bad_r ? beta_fall_r : beta_full_r;
    if (state_r == S_DIV && div_stat.done) beta_r <= div_quo;
  end

  mvg_ramp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mul_p[DivNumW-1:0]),
    .divisor  (transition_r),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (load_out) begin
      out_dt_r     <= dt_r;
      out_use_r    <= !bad_r;
      out_beta_r   <= beta_r;
      out_streak_r <= streak_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_dt_us       = out_dt_r;
  assign out_use_mag     = out_use_r;
  assign out_beta_out    = out_beta_r;
  assign out_good_streak = out_streak_r;

  // an accepted word moves the sequencer out of idle
  `MVG_ASSERT_NEXT(a_busy_after_accept, in_acc, !in_ready, "accepted word left sequencer idle")
  // a finished division always leads straight to the result state
  `MVG_ASSERT_NEXT(a_div_to_fin, state_r == S_DIV && div_stat.done, state_r == S_FIN, "division result dropped")
  // a 9-DOF gain never exceeds the full gain
  `MVG_ASSERT_NOW(a_gain_bound, out_valid && out_use_mag, out_beta_out <= beta_full_r, "ramp gain above full gain")
  // the fallback path always reports the 6-DOF gain
  `MVG_ASSERT_NOW(a_fallback_gain, out_valid && !out_use_mag, out_beta_out == beta_fall_r, "fallback gain mismatch")

endmodule
